>>> design/lpr_pkg.sv
package lpr_pkg;

    // Width of the push offset and declared length (payload max 60, offset max 62).
    localparam int POS_W = 6;
    // Width used for the room check (length + 2 against free slots, up to 65537).
    localparam int CMP_W = 18;

    typedef enum logic [1:0] {
        KIND_PUSH = 2'd0,
        KIND_BYTE = 2'd1,
        KIND_POP  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_TOO_LONG = 3'd1,
        STS_NO_ROOM  = 3'd2,
        STS_EMPTY    = 3'd3,
        STS_NO_LINK  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH,
        S_HDR_LO,
        S_HDR_HI,
        S_STAT,
        S_POP,
        S_HLO,
        S_HHI,
        S_IDX0,
        S_IDX1,
        S_IDX2,
        S_BODY
    } state_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] status;
        logic [7:0] data;
        logic       last;
    } res_t;

endpackage

>>> design/lpr_ram.sv
module lpr_ram
    import lpr_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/lpr_out.sv
module lpr_out
    import lpr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       emit,
    input  res_t       res,
    output logic       can_take,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output logic [1:0] result_kind,
    output logic [2:0] status,
    output logic [7:0] out_byte,
    output logic       last_of_run
);

    logic valid_reg;
    res_t res_reg;

    assign can_take = !valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_reg <= res;
        end
    end

    assign rsp_valid   = valid_reg;
    assign result_kind = res_reg.kind;
    assign status      = res_reg.status;
    assign out_byte    = res_reg.data;
    assign last_of_run = res_reg.last;

endmodule

>>> design/lpr_ctrl.sv
module lpr_ctrl
    import lpr_pkg::*;
#(
    parameter int RING_BYTES = 1024,
    parameter int PACKET_MAX = 60,
    parameter int PW         = 10
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  logic          opcode,
    input  logic [15:0]   pkt_len,
    input  logic          first_byte,
    input  logic          last_byte,
    input  logic [7:0]    data_byte,
    input  logic          link_ready,
    output logic          mem_we,
    output logic [PW-1:0] mem_waddr,
    output logic [7:0]    mem_wdata,
    output logic          mem_re,
    output logic [PW-1:0] mem_raddr,
    input  logic [7:0]    mem_rdata,
    output logic          emit,
    output res_t          res,
    input  logic          can_take
);

    localparam logic [PW:0]  RING_SZ   = (PW+1)'(RING_BYTES);
    localparam logic [15:0]  PKT_MAX_L = 16'(PACKET_MAX);

    function automatic logic [PW-1:0] wrap_add(logic [PW-1:0] a, logic [PW-1:0] b);
        logic [PW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= RING_SZ)
        begin
            s = s - RING_SZ;
        end
        return s[PW-1:0];
    endfunction

    state_t state_reg, state_next;

    // latched request
    logic [15:0]   len_reg, len_next;
    logic          first_reg, first_next;
    logic          last_reg, last_next;
    logic [7:0]    data_reg, data_next;
    logic          link_reg, link_next;

    // ring and push state
    logic [PW-1:0]    wp_reg, wp_next;
    logic [PW-1:0]    rp_reg, rp_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             acc_reg, acc_next;
    logic [POS_W-1:0] decl_reg, decl_next;
    logic [2:0]       verdict_reg, verdict_next;
    logic [15:0]      cnt_reg, cnt_next;

    // pop state
    logic [7:0]       len_lo_reg, len_lo_next;
    logic [POS_W-1:0] rem_reg, rem_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [1:0]       stat_kind_reg, stat_kind_next;
    logic [2:0]       stat_code_reg, stat_code_next;

    // working values
    logic [PW:0]      used;
    logic [PW:0]      free_slots;
    logic             acc_w;
    logic [POS_W-1:0] decl_w;
    logic [POS_W-1:0] pos_w;
    logic [15:0]      hdr;
    logic [PW-1:0]    rp_plus2;

    assign used       = {1'b0, wp_reg} - {1'b0, rp_reg} + ((wp_reg < rp_reg) ? RING_SZ : '0);
    assign free_slots = RING_SZ - used;
    assign hdr        = {mem_rdata, len_lo_reg};
    assign rp_plus2   = wrap_add(rp_reg, PW'(2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            wp_reg      <= '0;
            rp_reg      <= '0;
            pos_reg     <= '0;
            acc_reg     <= 1'b0;
            decl_reg    <= '0;
            verdict_reg <= STS_OK;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            rp_reg      <= rp_next;
            pos_reg     <= pos_next;
            acc_reg     <= acc_next;
            decl_reg    <= decl_next;
            verdict_reg <= verdict_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg       <= len_next;
        first_reg     <= first_next;
        last_reg      <= last_next;
        data_reg      <= data_next;
        link_reg      <= link_next;
        len_lo_reg    <= len_lo_next;
        rem_reg       <= rem_next;
        rd_ptr_reg    <= rd_ptr_next;
        stat_kind_reg <= stat_kind_next;
        stat_code_reg <= stat_code_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        data_next      = data_reg;
        link_next      = link_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        pos_next       = pos_reg;
        acc_next       = acc_reg;
        decl_next      = decl_reg;
        verdict_next   = verdict_reg;
        cnt_next       = cnt_reg;
        len_lo_next    = len_lo_reg;
        rem_next       = rem_reg;
        rd_ptr_next    = rd_ptr_reg;
        stat_kind_next = stat_kind_reg;
        stat_code_next = stat_code_reg;
        acc_w          = acc_reg;
        decl_w         = decl_reg;
        pos_w          = pos_reg;
        mem_we         = 1'b0;
        mem_waddr      = wp_reg;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = rp_reg;
        emit           = 1'b0;
        res            = '0;
        req_stall      = (state_reg != S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    len_next   = pkt_len;
                    first_next = first_byte;
                    last_next  = last_byte;
                    data_next  = data_byte;
                    link_next  = link_ready;
                    state_next = opcode ? S_POP : S_PUSH;
                end
            end

            S_PUSH:
            begin
                // packet start: check length and room, one slot stays free
                if (first_reg)
                begin
                    acc_w = 1'b0;
                    if (len_reg > PKT_MAX_L)
                    begin
                        verdict_next = STS_TOO_LONG;
                    end
                    else if ((CMP_W'(len_reg) + CMP_W'(2)) >= CMP_W'(free_slots))
                    begin
                        verdict_next = STS_NO_ROOM;
                    end
                    else
                    begin
                        verdict_next = STS_OK;
                        acc_w        = 1'b1;
                        decl_w       = len_reg[POS_W-1:0];
                        pos_w        = POS_W'(2);
                    end
                end
                // bytes beyond the declared length are dropped
                if (acc_w && ((pos_w - POS_W'(2)) < decl_w))
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wrap_add(wp_reg, PW'(pos_w));
                    mem_wdata = data_reg;
                    pos_w     = pos_w + POS_W'(1);
                end
                acc_next  = acc_w;
                decl_next = decl_w;
                pos_next  = pos_w;
                if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (acc_w)
                begin
                    state_next = S_HDR_LO;
                end
                else
                begin
                    stat_kind_next = KIND_PUSH;
                    stat_code_next = verdict_next;
                    state_next     = S_STAT;
                end
            end

            S_HDR_LO:
            begin
                // header holds the byte count actually received
                mem_we     = 1'b1;
                mem_waddr  = wp_reg;
                mem_wdata  = 8'(pos_reg - POS_W'(2));
                state_next = S_HDR_HI;
            end

            S_HDR_HI:
            begin
                mem_we         = 1'b1;
                mem_waddr      = wrap_add(wp_reg, PW'(1));
                mem_wdata      = '0;
                wp_next        = wrap_add(wp_reg, PW'(pos_reg));
                acc_next       = 1'b0;
                pos_next       = '0;
                stat_kind_next = KIND_PUSH;
                stat_code_next = verdict_reg;
                state_next     = S_STAT;
            end

            S_STAT:
            begin
                if (can_take)
                begin
                    emit       = 1'b1;
                    res.kind   = stat_kind_reg;
                    res.status = stat_code_reg;
                    res.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_POP:
            begin
                if (!link_reg)
                begin
                    stat_kind_next = KIND_POP;
                    stat_code_next = STS_NO_LINK;
                    state_next     = S_STAT;
                end
                else if (rp_reg == wp_reg)
                begin
                    stat_kind_next = KIND_POP;
                    stat_code_next = STS_EMPTY;
                    state_next     = S_STAT;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = rp_reg;
                    state_next = S_HLO;
                end
            end

            S_HLO:
            begin
                len_lo_next = mem_rdata;
                mem_re      = 1'b1;
                mem_raddr   = wrap_add(rp_reg, PW'(1));
                state_next  = S_HHI;
            end

            S_HHI:
            begin
                // empty or oversize header: skip it and look again
                if (hdr == '0 || hdr > PKT_MAX_L)
                begin
                    rp_next    = rp_plus2;
                    state_next = S_POP;
                end
                else
                begin
                    rem_next    = hdr[POS_W-1:0];
                    rd_ptr_next = rp_plus2;
                    state_next  = S_IDX0;
                end
            end

            S_IDX0:
            begin
                if (can_take)
                begin
                    emit       = 1'b1;
                    res.kind   = KIND_BYTE;
                    res.data   = cnt_reg[7:0];
                    state_next = S_IDX1;
                end
            end

            S_IDX1:
            begin
                if (can_take)
                begin
                    emit       = 1'b1;
                    res.kind   = KIND_BYTE;
                    res.data   = cnt_reg[15:8];
                    state_next = S_IDX2;
                end
            end

            S_IDX2:
            begin
                if (can_take)
                begin
                    emit        = 1'b1;
                    res.kind    = KIND_BYTE;
                    mem_re      = 1'b1;
                    mem_raddr   = rd_ptr_reg;
                    rd_ptr_next = wrap_add(rd_ptr_reg, PW'(1));
                    state_next  = S_BODY;
                end
            end

            S_BODY:
            begin
                // read of the next byte goes out as the current one is taken
                if (can_take)
                begin
                    emit     = 1'b1;
                    res.kind = KIND_BYTE;
                    res.data = mem_rdata;
                    res.last = (rem_reg == POS_W'(1));
                    rem_next = rem_reg - POS_W'(1);
                    if (rem_reg == POS_W'(1))
                    begin
                        rp_next    = rd_ptr_reg;
                        cnt_next   = cnt_reg + 16'd1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        mem_re      = 1'b1;
                        mem_raddr   = rd_ptr_reg;
                        rd_ptr_next = wrap_add(rd_ptr_reg, PW'(1));
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> design/length_prefixed_packet_ring.sv
// Push: a request that is not a packet's last byte returns the sequencer to idle; a last byte of a
// stored packet gives its status after the two header writes, others without them.
// Pop: each stored header is read in S_POP and S_HLO and checked in S_HHI (single registered read port), then the index
// bytes and payload stream one per cycle while the output register takes them; the input stalls meanwhile.
// Throughput: one request at a time; the output register lets the last result wait.
// Reset: pointers, counter and push state clear at once; ring contents stay undefined.
module length_prefixed_packet_ring
    import lpr_pkg::*;
#(
    parameter int RING_BYTES = 1024,
    parameter int PACKET_MAX = 60
)
(
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        opcode,
    input  logic [15:0] pkt_len,
    input  logic        first_byte,
    input  logic        last_byte,
    input  logic [7:0]  data_byte,
    input  logic        link_ready,
    // result channel
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [1:0]  result_kind,
    output logic [2:0]  status,
    output logic [7:0]  out_byte,
    output logic        last_of_run
);

    localparam int PW = $clog2(RING_BYTES);

    logic          mem_we;
    logic [PW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [PW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;
    logic          emit;
    res_t          res;
    logic          can_take;

    // Byte ring: one write and one registered read port. Writes happen only while a push
    // request is processed and reads only during a pop, so they never touch the same
    // entry in the same cycle and no forwarding is needed.
    lpr_ram #(
        .DEPTH (RING_BYTES),
        .AW    (PW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Sequencer: room check, payload and header writes, header skip, packet streaming.
    lpr_ctrl #(
        .RING_BYTES (RING_BYTES),
        .PACKET_MAX (PACKET_MAX),
        .PW         (PW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .opcode     (opcode),
        .pkt_len    (pkt_len),
        .first_byte (first_byte),
        .last_byte  (last_byte),
        .data_byte  (data_byte),
        .link_ready (link_ready),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata),
        .emit       (emit),
        .res        (res),
        .can_take   (can_take)
    );

    // Result register, separates the sequencer from the downstream stall.
    lpr_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .emit        (emit),
        .res         (res),
        .can_take    (can_take),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .result_kind (result_kind),
        .status      (status),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

    // an accepted request raises the stall in the next cycle
    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted back to back");

    // a result is only handed over when the output register can take it
    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> can_take)
        else $error("result emitted into a full output register");

    // ring reads and writes never share a cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("ring read and write in the same cycle");

    // packet bytes always carry an ok status
    a_byte_status: assert property (@(posedge clk) disable iff (!rst_n)
        emit && res.kind == KIND_BYTE |-> res.status == STS_OK)
        else $error("packet byte with non-ok status");

endmodule

>>> tb/length_prefixed_packet_ring_tb.sv
module length_prefixed_packet_ring_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lpr_pkg::*;

    // Sizes match the block's default parameters.
    localparam int RING_BYTES = 1024;
    localparam int PACKET_MAX = 60;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Cycles with no handshake on either channel before the run is called hung.
    // A pop that skips a ring full of empty headers makes no handshake meanwhile.
    localparam int IDLE_LIMIT = 10000;
    // Length of the one long receiver hold-off, in cycles.
    localparam int LONG_HOLD  = 400;

    typedef struct {
        logic        op;
        logic [15:0] len;
        logic        first;
        logic        last;
        logic [7:0]  data;
        logic        link;
    } ring_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic        opcode = OP_PUSH;
    logic [15:0] pkt_len = 16'h0000;
    logic        first_byte = 1'b0;
    logic        last_byte = 1'b0;
    logic [7:0]  data_byte = 8'h00;
    logic        link_ready = 1'b0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    logic [1:0]  result_kind;
    logic [2:0]  status;
    logic [7:0]  out_byte;
    logic        last_of_run;

    length_prefixed_packet_ring dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .opcode      (opcode),
        .pkt_len     (pkt_len),
        .first_byte  (first_byte),
        .last_byte   (last_byte),
        .data_byte   (data_byte),
        .link_ready  (link_ready),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .result_kind (result_kind),
        .status      (status),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Requests waiting to be offered, and results owed by the block, oldest first.
    ring_req_t req_queue[$];
    res_t      due_results[$];
    ring_req_t cur_req;

    // Idle / stall mix, changed only between phases.
    int send_idle_pct = 30;
    int rcv_stall_pct = 61;

    // Long hold-off handshake: stimulus bumps hold_requests, the monitor serves it.
    int hold_requests = 0;
    int holds_taken = 0;
    int hold_left = 0;

    int n_errors = 0;
    int n_results = 0;
    int n_accepted = 0;
    int n_queued = 0;
    int n_packets = 0;

    // ------------------------------------------------------------------
    // Shadow of the ring. Entries are only read after a commit wrote them,
    // so the array is left at X until then.
    // ------------------------------------------------------------------
    logic [7:0]  ring_mem [RING_BYTES];
    logic [9:0]  wr_ptr = '0;
    logic [9:0]  rd_ptr = '0;
    int          push_ofs = 0;       // offset from wr_ptr of the next payload byte
    bit          push_open = 1'b0;   // an accepted packet is being received
    int          push_decl = 0;      // declared length of that packet
    status_t     push_sts = STS_OK;  // verdict of the latest packet start
    logic [15:0] pkt_index = '0;     // running index of the next sent packet

    function automatic void add_result(kind_t k, status_t s, logic [7:0] b, logic l);
        res_t r;
        r.kind   = k;
        r.status = s;
        r.data   = b;
        r.last   = l;
        due_results.push_back(r);
    endfunction

    // Advances the shadow ring by one accepted request and queues what it owes.
    function automatic void predict_ring_step(input ring_req_t rq);
        logic [9:0]  used;
        logic [15:0] count;
        logic [15:0] plen;
        bit          sent;
        if (rq.op == OP_PUSH)
        begin
            if (rq.first)
            begin
                // A new start always drops whatever packet was still open.
                used = wr_ptr - rd_ptr;
                push_open = 1'b0;
                if (rq.len > PACKET_MAX)
                    push_sts = STS_TOO_LONG;
                // Header plus payload must fit and still leave one slot free.
                else if (int'(rq.len) + 2 >= RING_BYTES - int'(used))
                    push_sts = STS_NO_ROOM;
                else
                begin
                    push_sts  = STS_OK;
                    push_open = 1'b1;
                    push_decl = int'(rq.len);
                    push_ofs  = 2;
                end
            end
            // Bytes past the declared length are dropped.
            if (push_open && push_ofs - 2 < push_decl)
            begin
                ring_mem[wr_ptr + 10'(push_ofs)] = rq.data;
                push_ofs++;
            end
            if (rq.last)
            begin
                // Header carries the count actually received, not the declared one.
                if (push_open)
                begin
                    count = 16'(push_ofs - 2);
                    ring_mem[wr_ptr] = count[7:0];
                    ring_mem[wr_ptr + 10'd1] = count[15:8];
                    wr_ptr = wr_ptr + 10'(push_ofs);
                    push_open = 1'b0;
                    push_ofs = 0;
                end
                add_result(KIND_PUSH, push_sts, 8'h00, 1'b1);
            end
        end
        else if (!rq.link)
            add_result(KIND_POP, STS_NO_LINK, 8'h00, 1'b1);
        else
        begin
            sent = 1'b0;
            while (rd_ptr != wr_ptr && !sent)
            begin
                plen = {ring_mem[rd_ptr + 10'd1], ring_mem[rd_ptr]};
                if (plen == 16'd0 || plen > PACKET_MAX)
                    rd_ptr = rd_ptr + 10'd2;    // empty or bogus header: skip
                else
                begin
                    add_result(KIND_BYTE, STS_OK, pkt_index[7:0], 1'b0);
                    add_result(KIND_BYTE, STS_OK, pkt_index[15:8], 1'b0);
                    add_result(KIND_BYTE, STS_OK, 8'h00, 1'b0);
                    for (int i = 0; i < int'(plen); i++)
                        add_result(KIND_BYTE, STS_OK, ring_mem[rd_ptr + 10'd2 + 10'(i)],
                                   i == int'(plen) - 1);
                    rd_ptr = rd_ptr + 10'd2 + 10'(plen);
                    pkt_index++;
                    n_packets++;
                    sent = 1'b1;
                end
            end
            if (!sent)
                add_result(KIND_POP, STS_EMPTY, 8'h00, 1'b1);
        end
    endfunction

    // ------------------------------------------------------------------
    // Request driver: one request held on the ports until taken; the
    // prediction runs at the edge that takes it.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : request_driver
        ring_req_t nxt;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                predict_ring_step(cur_req);
                n_accepted++;
            end
            if (!req_valid || !req_stall)
            begin
                if (req_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = req_queue.pop_front();
                    cur_req = nxt;
                    opcode     <= nxt.op;
                    pkt_len    <= nxt.len;
                    first_byte <= nxt.first;
                    last_byte  <= nxt.last;
                    data_byte  <= nxt.data;
                    link_ready <= nxt.link;
                    req_valid  <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and receiver stall. A pending long hold-off takes
    // priority over the random stall mix.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_monitor
        res_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                n_results++;
                if (due_results.size() == 0)
                begin
                    $error("unexpected result: result_kind %0d status %0d out_byte %0h last %0b",
                           result_kind, status, out_byte, last_of_run);
                    n_errors++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (result_kind !== want.kind)
                    begin
                        $error("result_kind: expected %0d, got %0d", want.kind, result_kind);
                        n_errors++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        n_errors++;
                    end
                    if (out_byte !== want.data)
                    begin
                        $error("out_byte: expected %0h, got %0h", want.data, out_byte);
                        n_errors++;
                    end
                    if (last_of_run !== want.last)
                    begin
                        $error("last_of_run: expected %0b, got %0b", want.last, last_of_run);
                        n_errors++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                rsp_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else if (holds_taken != hold_requests)
            begin
                holds_taken <= holds_taken + 1;
                hold_left   <= LONG_HOLD;
                rsp_stall   <= 1'b1;
            end
            else
                rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
        end
    end

    // Watchdog: fails the run once the idle count reaches IDLE_LIMIT; any handshake or reset clears it.
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || !rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL length_prefixed_packet_ring");
        $finish;
    end

    // ------------------------------------------------------------------
    // Request builders
    // ------------------------------------------------------------------
    task automatic push_item(input logic [15:0] len, input logic first, input logic last,
                             input logic [7:0] data);
        ring_req_t rq;
        rq.op    = OP_PUSH;
        rq.len   = len;
        rq.first = first;
        rq.last  = last;
        rq.data  = data;
        rq.link  = 1'($urandom);
        req_queue.push_back(rq);
        n_queued++;
    endtask

    // Only link matters on a pop; the other fields get noise.
    task automatic pop_item(input logic link);
        ring_req_t rq;
        rq.op    = OP_POP;
        rq.len   = 16'($urandom);
        rq.first = 1'($urandom);
        rq.last  = 1'($urandom);
        rq.data  = 8'($urandom);
        rq.link  = link;
        req_queue.push_back(rq);
        n_queued++;
    endtask

    // n_sent byte requests; length rides on the first, last flag only if closed.
    task automatic queue_packet(input int decl, input int n_sent, input bit close);
        for (int i = 0; i < n_sent; i++)
            push_item(i == 0 ? 16'(decl) : 16'($urandom), i == 0,
                      close && i == n_sent - 1, 8'($urandom));
    endtask

    // Mostly well-formed packets and pops, with some malformed traffic mixed in.
    task automatic queue_random(input int n_items);
        int start;
        int pick;
        int decl;
        int n_sent;
        start = n_queued;
        while (n_queued - start < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
                pop_item($urandom_range(7) != 0);
            else if (pick < 34)
                push_item(16'($urandom), 1'b0, 1'b1, 8'($urandom));     // stray last
            else if (pick < 40)
                queue_packet($urandom_range(PACKET_MAX + 1, 65535), $urandom_range(1, 3), 1'b1);
            else
            begin
                decl = ($urandom_range(7) == 0) ? PACKET_MAX : $urandom_range(0, 12);
                n_sent = (decl == 0) ? 1 : decl;
                pick = $urandom_range(99);
                if (pick < 10)
                    n_sent = $urandom_range(1, n_sent);          // ends early
                else if (pick < 20)
                    n_sent = n_sent + $urandom_range(1, 3);      // runs past its length
                // A few are left open so the next start cuts them off.
                queue_packet(decl, n_sent, pick < 94);
            end
        end
    endtask

    // Sender pause: nothing left to offer and every owed result has arrived.
    task automatic drain_all();
        while (req_queue.size() > 0 || req_valid || due_results.size() > 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus. All updates of shared state happen at the falling edge.
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Phase 1: sender idles 30%, receiver stalls 61%.
        pop_item(1'b0);                             // no link
        pop_item(1'b1);                             // nothing stored yet
        push_item(16'h0000, 1'b0, 1'b1, 8'h00);     // stray last, ok right after reset
        push_item(16'd1, 1'b1, 1'b1, 8'hFF);        // single-byte packet
        push_item(16'd0, 1'b1, 1'b1, 8'hAA);        // bare header, skipped on pop
        push_item(16'd61, 1'b1, 1'b0, 8'h55);       // one over the limit
        push_item(16'h1234, 1'b0, 1'b1, 8'h66);
        push_item(16'h0000, 1'b0, 1'b1, 8'h00);     // stray last repeats too-long verdict
        push_item(16'hFFFF, 1'b1, 1'b1, 8'hFF);     // largest length field
        push_item(16'd4, 1'b1, 1'b0, 8'h00);        // ends after 3 of 4 bytes
        push_item(16'hFFFF, 1'b0, 1'b0, 8'h55);
        push_item(16'h0000, 1'b0, 1'b1, 8'h80);
        push_item(16'd2, 1'b1, 1'b0, 8'h01);        // 4 bytes sent for 2 declared
        push_item(16'h0000, 1'b0, 1'b0, 8'h02);
        push_item(16'h0000, 1'b0, 1'b0, 8'h03);
        push_item(16'h0000, 1'b0, 1'b1, 8'h04);
        push_item(16'd5, 1'b1, 1'b0, 8'h11);        // cut off by a new start
        push_item(16'h0000, 1'b0, 1'b0, 8'h22);
        push_item(16'd1, 1'b1, 1'b1, 8'h33);
        pop_item(1'b1);                             // one-byte packet
        pop_item(1'b1);                             // skips the bare header
        pop_item(1'b0);
        pop_item(1'b1);
        pop_item(1'b1);
        pop_item(1'b1);                             // empty again
        queue_random(45);

        // Long receiver hold-off while requests keep coming, so the block backs up.
        while (req_queue.size() >= 30)
            @(negedge clk);
        hold_requests++;
        drain_all();

        // Phase 2: sender idles 61%, receiver stalls 30%.
        send_idle_pct = 61;
        rcv_stall_pct = 30;
        queue_random(45);
        drain_all();

        // Phase 3: no idling on either side, requests offered back to back.
        send_idle_pct = 0;
        rcv_stall_pct = 0;
        queue_random(50);
        drain_all();

        // Let any stray result show up before the verdict.
        repeat (100) @(negedge clk);

        $display("Checked %0d requests and %0d results over three stall mixes and a long",
                 n_accepted, n_results);
        $display("receiver hold-off, with malformed, oversize and cut-off packets: %0d sent.",
                 n_packets);
        if (n_errors == 0 && due_results.size() == 0)
            $display("PASS length_prefixed_packet_ring");
        else
            $display("FAIL length_prefixed_packet_ring");
        $finish;
    end

endmodule
